// File: rtl/f2i_pkg.sv
// Package: shared types and constants for the float to integer converter.
`timescale 1ns / 1ps
`default_nettype none
package f2i_pkg;
  localparam int unsigned CmdW = 3;
  localparam int unsigned FltW = 32;
  localparam int unsigned ResW = 64;

  // Target type codes.
  localparam logic [CmdW-1:0] CMD_U8  = 3'd0;
  localparam logic [CmdW-1:0] CMD_U16 = 3'd1;
  localparam logic [CmdW-1:0] CMD_U32 = 3'd2;
  localparam logic [CmdW-1:0] CMD_U64 = 3'd3;
  localparam logic [CmdW-1:0] CMD_S8  = 3'd4;
  localparam logic [CmdW-1:0] CMD_S16 = 3'd5;
  localparam logic [CmdW-1:0] CMD_S32 = 3'd6;
  localparam logic [CmdW-1:0] CMD_S64 = 3'd7;

  localparam logic [7:0] EXP_BIAS = 8'd127;
  localparam logic [7:0] EXP_OVER = 8'd191;
  localparam logic [7:0] EXP_ALL1 = 8'hFF;

  // Stage 1 to stage 2: decoded fields.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            neg;
    logic            nan;
    logic            over;
    logic            lt1;
    logic [23:0]     sig;
    logic [7:0]      ex;
  } dec_t;

  // Stage 2 to stage 3: truncated magnitude.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            neg;
    logic            nan;
    logic            over;
    logic [ResW-1:0] mag;
  } mag_t;
endpackage
`default_nettype wire

// File: rtl/f2i_stream_if.sv
// Interface: valid/ready stream channel carrying a generic payload.
`timescale 1ns / 1ps
`default_nettype none
interface f2i_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/f2i_decode.sv
// Stage 1: unpacks the float and classifies special cases.
`timescale 1ns / 1ps
`default_nettype none
module f2i_decode (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_in,
  input  wire logic [f2i_pkg::CmdW-1:0] cmd,
  input  wire logic [f2i_pkg::FltW-1:0] bits,
  output logic                        vld_r,
  output f2i_pkg::dec_t               dec_r
);
  import f2i_pkg::*;
  logic [7:0] ex;
  dec_t dec_nxt;

  // Classify the exponent field.
  always_comb begin
    ex = bits[30:23];
    dec_nxt.cmd  = cmd;
    dec_nxt.neg  = bits[31];
    dec_nxt.nan  = (ex == EXP_ALL1) && (bits[22:0] != 23'd0);
    dec_nxt.over = (ex >= EXP_OVER);
    dec_nxt.lt1  = (ex < EXP_BIAS);
    dec_nxt.sig  = {1'b1, bits[22:0]};
    dec_nxt.ex   = ex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/f2i_shift.sv
// Stage 2: aligns the significand into an integer magnitude.
`timescale 1ns / 1ps
`default_nettype none
module f2i_shift (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  f2i_pkg::dec_t      dec,
  output logic               vld_r,
  output f2i_pkg::mag_t      mag_r
);
  import f2i_pkg::*;
  logic [5:0] sh;
  logic [86:0] wide;
  mag_t mag_nxt;

  // The value is sig * 2^(ex-150); place it in a window and keep the integer part.
  always_comb begin
    sh = dec.ex[5:0] - 6'd63;
    wide = {63'd0, dec.sig} << sh;
    mag_nxt.cmd  = dec.cmd;
    mag_nxt.neg  = dec.neg;
    mag_nxt.nan  = dec.nan;
    mag_nxt.over = dec.over;
    mag_nxt.mag  = (dec.lt1 || dec.over) ? '0 : wide[86:23];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/f2i_clamp.sv
// Stage 3: saturates to the target range and applies the sign.
`timescale 1ns / 1ps
`default_nettype none
module f2i_clamp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     vld_in,
  input  f2i_pkg::mag_t                 m,
  output logic                          vld_r,
  output logic [f2i_pkg::ResW-1:0]      res_r
);
  import f2i_pkg::*;
  logic [ResW-1:0] umax;
  logic [ResW-1:0] half;
  logic [ResW-1:0] res_nxt;

  // Limits for the selected width.
  always_comb begin
    case (m.cmd[1:0])
      2'd0:    umax = 64'h0000_0000_0000_00FF;
      2'd1:    umax = 64'h0000_0000_0000_FFFF;
      2'd2:    umax = 64'h0000_0000_FFFF_FFFF;
      default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    half = {1'b0, umax[ResW-1:1]} + 64'd1;
  end

  // Saturation and sign.
  always_comb begin
    if (m.nan) begin
      res_nxt = '0;
    end else if (!m.cmd[2]) begin
      if (m.neg)                     res_nxt = '0;
      else if (m.over || m.mag > umax) res_nxt = umax;
      else                           res_nxt = m.mag;
    end else if (!m.neg) begin
      if (m.over || m.mag > half - 64'd1) res_nxt = half - 64'd1;
      else                                res_nxt = m.mag;
    end else begin
      if (m.over || m.mag > half) res_nxt = 64'd0 - half;
      else                        res_nxt = 64'd0 - m.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/float32_to_int_saturating.sv
// Top level: three-stage saturating float32 to integer converter.
//
//   channel  dir  payload
//   in_      in   cmd[2:0], value_bits[31:0]
//   out_     out  result_bits[63:0]
//
// One transfer per cycle is sustained while the output takes results.
// The pipeline advances when the last stage is empty or its result is taken.
// A stall freezes all stages together, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module float32_to_int_saturating (
  input  wire logic   clk,
  input  wire logic   rst_n,
  f2i_stream_if.sink   in_ch,
  f2i_stream_if.source out_ch
);
  import f2i_pkg::*;
  logic en;
  logic v1, v2, v3;
  dec_t d1;
  mag_t m2;
  logic [ResW-1:0] res;

  // Global stall when the output holds an untaken result.
  assign en = !v3 || out_ch.ready;
  assign in_ch.ready = en;

  f2i_decode u_dec (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_ch.valid),
    .cmd(in_ch.data[FltW +: CmdW]), .bits(in_ch.data[FltW-1:0]),
    .vld_r(v1), .dec_r(d1)
  );
  f2i_shift u_sh (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v1), .dec(d1),
    .vld_r(v2), .mag_r(m2)
  );
  f2i_clamp u_cl (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v2), .m(m2),
    .vld_r(v3), .res_r(res)
  );

  assign out_ch.valid = v3;
  assign out_ch.data  = res;

`ifndef ASSERT_OFF
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3 && !out_ch.ready |=> v3 && $stable(res)) else $error("result changed in stall");
  // NaN in stage 3 must give zero.
  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    en && v2 && m2.nan |=> res == '0) else $error("NaN not zero");
  // Unsigned targets never see a negative number forwarded.
  a_uneg: assert property (@(posedge clk) disable iff (!rst_n)
    en && v2 && !m2.cmd[2] && m2.neg |=> res == '0) else $error("unsigned negative");
`endif
endmodule
`default_nettype wire

// File: dv/float32_to_int_saturating_tb.sv
// Testbench for the saturating float32 to integer converter.
`timescale 1ns / 1ps
module float32_to_int_saturating_tb;
  import f2i_pkg::*;

  logic clk;
  logic rst_n;
  bit   failed;
  int   n_sent;
  int   n_checked;
  int   n_nan;
  int   n_sat;

  f2i_stream_if #(.W(CmdW + FltW)) in_ch ();
  f2i_stream_if #(.W(ResW)) out_ch ();

  logic [ResW-1:0] expected_ints[$];

  float32_to_int_saturating u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compute the saturated, truncated integer for one float pattern.
  function automatic logic [ResW-1:0] convert_float(logic [CmdW-1:0] cmd,
                                                    logic [FltW-1:0] bits);
    logic            neg;
    logic [7:0]      ex;
    logic [22:0]     frac;
    logic            over;
    logic [ResW-1:0] mag;
    logic [ResW-1:0] umax;
    logic [ResW-1:0] half;
    int unsigned     nbits;
    neg   = bits[31];
    ex    = bits[30:23];
    frac  = bits[22:0];
    over  = 1'b0;
    mag   = '0;
    nbits = 8 << cmd[1:0];
    if (ex == EXP_ALL1 && frac != 0) return '0;
    if (ex == EXP_ALL1 || ex >= EXP_OVER) begin
      over = 1'b1;
    end else if (ex >= EXP_BIAS) begin
      mag = {40'd0, 1'b1, frac};
      if (ex >= 8'd150) mag = mag << (ex - 8'd150);
      else mag = mag >> (8'd150 - ex);
    end
    if (!cmd[2]) begin
      umax = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
      if (neg) return '0;
      return (over || mag > umax) ? umax : mag;
    end
    half = 64'd1 << (nbits - 1);
    if (!neg) return (over || mag > half - 64'd1) ? half - 64'd1 : mag;
    return (over || mag > half) ? (64'd0 - half) : (64'd0 - mag);
  endfunction

  // Send one conversion request and queue its expected result.
  // Valid stays high after the transfer; it drops only when a gap follows.
  task automatic send_item(logic [CmdW-1:0] cmd, logic [FltW-1:0] bits);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {cmd, bits};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_ints.push_back(convert_float(cmd, bits));
    if (bits[30:23] == EXP_ALL1 && bits[22:0] != 0) n_nan++;
    n_sent++;
  endtask

  // Result checker with random backpressure.
  initial begin
    logic [ResW-1:0] want;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (expected_ints.size() == 0) begin
        $error("result_bits: no result expected, actual %h", out_ch.data);
        failed = 1'b1;
      end else begin
        want = expected_ints.pop_front();
        if (out_ch.data !== want) begin
          $error("result_bits: expected %h actual %h", want, out_ch.data);
          failed = 1'b1;
        end
        n_checked++;
      end
    end
  end

  // Boundary values for every target type and each special case.
  task automatic test_directed();
    logic [FltW-1:0] vals[12];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0001, 32'h0000_0001, 32'hBF7F_FFFF, 32'h437F_0000,
             32'h4F80_0000, 32'hCF00_0000, 32'h5F80_0000, 32'hFFFF_FFFF};
    for (int c = 0; c < 8; c++) begin
      send_item(c[2:0], vals[c]);
      send_item(c[2:0], vals[c + 4]);
      send_item(c[2:0], 32'hC300_0000);
    end
    send_item(CMD_S64, 32'hDF00_0000);
  endtask

  // Hold off until the pipeline has drained, then send one U64 conversion.
  task automatic test_drain();
    in_ch.valid <= 1'b0;
    while (expected_ints.size() != 0) @(posedge clk);
    send_item(CMD_U64, 32'h7F7F_FFFF);
  endtask

  // Random patterns, mostly with exponents around the integer range.
  task automatic test_random(int count);
    logic [FltW-1:0] bits;
    for (int i = 0; i < count; i++) begin
      bits = $urandom();
      if ($urandom_range(0, 3) != 0) bits[30:23] = 8'($urandom_range(120, 195));
      send_item(CmdW'($urandom_range(0, 7)), bits);
      if (bits[30:23] >= 8'd134) n_sat++;
    end
  endtask

  // Main sequence.
  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(340);
    test_drain();
    test_random(340);
    in_ch.valid <= 1'b0;
    while (expected_ints.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d conversions over all eight targets, checked %0d results.",
             n_sent, n_checked);
    $display("Included %0d NaN patterns and %0d large-exponent values.", n_nan, n_sat);
    if (!failed) begin
      $display("float32_to_int_saturating verification clean");
    end else begin
      $display("float32_to_int_saturating verification failed");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2ms;
    $display("float32_to_int_saturating verification failed");
    $finish;
  end
endmodule
